@@ rtl/core/pnrx_pkg.sv @@
// Shared widths, bus map and item codes for the packet receive ring adapter.
`timescale 1ns / 1ps

package pnrx_pkg;

   // Item field widths
   localparam int FUNC_W    = 2;
   localparam int ADDR_W    = 13;
   localparam int DATA_W    = 32;
   localparam int SIZE_W    = 3;
   localparam int BYTE_W    = 8;
   localparam int IDX_W     = 11;
   localparam int SEND_W    = 11;
   localparam int BUS_BYTES = 4;

   // Default geometry (both powers of two)
   localparam int QUEUE_DEPTH = 32;
   localparam int BUF_BYTES   = 2048;

   // Bus map
   localparam logic [ADDR_W-1:0] REG_HEAD     = ADDR_W'(0);
   localparam logic [ADDR_W-1:0] REG_TAIL     = ADDR_W'(4);
   localparam logic [ADDR_W-1:0] REG_SEND     = ADDR_W'(8);
   localparam logic [ADDR_W-1:0] REG_SEND_LEN = ADDR_W'(12);
   localparam logic [ADDR_W-1:0] REG_RX_LEN   = ADDR_W'(16);
   localparam logic [ADDR_W-1:0] TX_BASE      = ADDR_W'(2048);
   localparam logic [ADDR_W-1:0] RX_BASE      = ADDR_W'(4096);

   // Access size codes
   localparam logic [SIZE_W-1:0] SIZE_HALF = SIZE_W'(2);
   localparam logic [SIZE_W-1:0] SIZE_WORD = SIZE_W'(4);

   // Item kinds
   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ     = 2'd0,
      FUNC_WRITE    = 2'd1,
      FUNC_RX_BYTE  = 2'd2,
      FUNC_TX_FETCH = 2'd3
   } func_type;

endpackage

@@ rtl/core/pnrx_chan_if.sv @@
// Valid/ready channel interfaces for request and response transactions.
`timescale 1ns / 1ps

interface pnrx_req_if;
   logic                               valid;
   logic                               ready;
   logic [pnrx_pkg::FUNC_W-1:0]        func;
   logic [pnrx_pkg::ADDR_W-1:0]        address;
   logic [pnrx_pkg::DATA_W-1:0]        wdata;
   logic [pnrx_pkg::SIZE_W-1:0]        size;
   logic [pnrx_pkg::BYTE_W-1:0]        rx_data;
   logic                               rx_last;
   logic [pnrx_pkg::IDX_W-1:0]         tx_index;

   modport source (output valid, func, address, wdata, size, rx_data, rx_last, tx_index,
                   input ready);
   modport sink   (input valid, func, address, wdata, size, rx_data, rx_last, tx_index,
                   output ready);
endinterface

interface pnrx_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pnrx_pkg::DATA_W-1:0]        rdata;
   logic                               irq;
   logic                               send_strobe;
   logic [pnrx_pkg::SEND_W-1:0]        send_length;
   logic [pnrx_pkg::BYTE_W-1:0]        tx_byte;

   modport source (output valid, rdata, irq, send_strobe, send_length, tx_byte,
                   input ready);
   modport sink   (input valid, rdata, irq, send_strobe, send_length, tx_byte,
                   output ready);
endinterface

@@ rtl/core/packet_nic_rx_ring_registers.sv @@
// Pipeline: an accepted request passes the registered buffer memory read, then the
// response register, which drives the response valid; a response stall holds both.
// Throughput: one transaction per cycle while the response side is ready; the four byte
// banks of each buffer give one read and one write port per bank per cycle.
// Reset: head, tail, send length, fill count, interrupt and the length valid bits clear;
// the byte buffers hold no reset value and need no clearing pass.
`timescale 1ns / 1ps

module packet_nic_rx_ring_registers #(
   parameter int QUEUE_DEPTH = pnrx_pkg::QUEUE_DEPTH,
   parameter int BUF_BYTES   = pnrx_pkg::BUF_BYTES
) (
   input  logic       clock,
   input  logic       reset,
   pnrx_req_if.sink   req_bus,
   pnrx_rsp_if.source rsp_bus
);

   localparam int QW   = $clog2(QUEUE_DEPTH);
   localparam int AW   = $clog2(BUF_BYTES);
   localparam int WW   = AW - 2;
   localparam int LW   = AW + 1;
   localparam int NB   = pnrx_pkg::BUS_BYTES;
   localparam int BW   = pnrx_pkg::BYTE_W;
   localparam int TXD  = BUF_BYTES / NB;
   localparam int RXD  = QUEUE_DEPTH * BUF_BYTES / NB;

   typedef enum logic [2:0] {
      TGT_HEAD, TGT_TAIL, TGT_SEND, TGT_SEND_LEN, TGT_RX_LEN, TGT_TX, TGT_RX, TGT_NONE
   } target_type;

   typedef enum logic [1:0] {SRC_VALUE, SRC_TX, SRC_RX, SRC_LEN} src_type;

   typedef struct packed {
      src_type                          src;
      logic                             fetch;
      logic [1:0]                       off_lo;
      logic [NB-1:0]                    byte_ok;
      logic [pnrx_pkg::DATA_W-1:0]      value;
      logic                             irq;
      logic                             strobe;
      logic [pnrx_pkg::SEND_W-1:0]      send_len;
   } meta_type;

   typedef struct packed {
      logic [pnrx_pkg::DATA_W-1:0]      rdata;
      logic                             irq;
      logic                             send_strobe;
      logic [pnrx_pkg::SEND_W-1:0]      send_length;
      logic [BW-1:0]                    tx_byte;
   } rsp_type;

   // Control state
   logic [QW-1:0]          head_ff, head_in;
   logic [QW-1:0]          tail_ff, tail_in;
   logic [AW-1:0]          tx_len_ff, tx_len_in;
   logic [LW-1:0]          fill_ff, fill_in;
   logic                   irq_ff, irq_in;
   logic [QUEUE_DEPTH-1:0] len_vld_ff, len_vld_in;
   logic                   s1_valid_ff, s1_valid_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   meta_type               meta_ff, meta_in;
   rsp_type                out_ff, out_in;

   // Memories and their registered read data
   logic [LW-1:0]          len_mem [QUEUE_DEPTH];
   logic [LW-1:0]          len_rd_ff;
   logic                   len_ok_ff;
   logic [BW-1:0]          tx_rd_ff [NB];
   logic [BW-1:0]          rx_rd_ff [NB];

   // Request decode
   pnrx_pkg::func_type     func;
   logic                   accept;
   logic                   s1_move;
   target_type             target;
   logic [pnrx_pkg::ADDR_W-1:0] tx_rel, rx_rel;
   logic                   idx_ok;
   logic [AW-1:0]          off;
   logic [2:0]             nbytes;
   logic [2:0]             size_bytes;
   logic [LW-1:0]          fill_next;
   logic                   rx_store_ok;
   logic [NB-1:0]          res_ok;

   // Per-bank controls
   logic [NB-1:0]          bank_ok;
   logic [1:0]             bank_lane [NB];
   logic [WW-1:0]          bank_word [NB];
   logic [NB-1:0]          tx_we;
   logic                   tx_re;
   logic                   rx_re;
   logic [NB-1:0]          rx_we;
   logic [WW-1:0]          tx_ra [NB];
   logic [BW-1:0]          tx_wd [NB];

   // Stage 1 assembly
   logic [pnrx_pkg::DATA_W-1:0] asm_data;

   assign func   = pnrx_pkg::func_type'(req_bus.func);
   assign s1_move = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !reset && (!s1_valid_ff || s1_move);
   assign accept = req_bus.valid && req_bus.ready;

   // Decode the bus target, with registers first and the transmit range over the receive range
   always_comb begin
      tx_rel = req_bus.address - pnrx_pkg::TX_BASE;
      rx_rel = req_bus.address - pnrx_pkg::RX_BASE;
      if (req_bus.address == pnrx_pkg::REG_HEAD) begin
         target = TGT_HEAD;
      end else if (req_bus.address == pnrx_pkg::REG_TAIL) begin
         target = TGT_TAIL;
      end else if (req_bus.address == pnrx_pkg::REG_SEND) begin
         target = TGT_SEND;
      end else if (req_bus.address == pnrx_pkg::REG_SEND_LEN) begin
         target = TGT_SEND_LEN;
      end else if (req_bus.address == pnrx_pkg::REG_RX_LEN) begin
         target = TGT_RX_LEN;
      end else if (req_bus.address >= pnrx_pkg::TX_BASE &&
                   32'(tx_rel) < 32'(BUF_BYTES)) begin
         target = TGT_TX;
      end else if (req_bus.address >= pnrx_pkg::RX_BASE &&
                   32'(rx_rel) < 32'(BUF_BYTES)) begin
         target = TGT_RX;
      end else begin
         target = TGT_NONE;
      end
   end

   // Pick the buffer offset and byte count of this transaction
   always_comb begin
      if (req_bus.size == pnrx_pkg::SIZE_HALF) begin
         size_bytes = 3'd2;
      end else if (req_bus.size == pnrx_pkg::SIZE_WORD) begin
         size_bytes = 3'd4;
      end else begin
         size_bytes = 3'd1;
      end
      idx_ok = 32'(req_bus.tx_index) < 32'(BUF_BYTES);
      off    = '0;
      nbytes = 3'd0;
      case (func)
         pnrx_pkg::FUNC_READ, pnrx_pkg::FUNC_WRITE: begin
            if (target == TGT_TX) begin
               off    = AW'(tx_rel);
               nbytes = size_bytes;
            end else if (target == TGT_RX) begin
               off    = AW'(rx_rel);
               nbytes = size_bytes;
            end
         end
         pnrx_pkg::FUNC_TX_FETCH: begin
            off    = AW'(req_bus.tx_index);
            nbytes = idx_ok ? 3'd1 : 3'd0;
         end
         default: begin
            off    = '0;
            nbytes = 3'd0;
         end
      endcase
   end

   // Map bytes to banks and drop any byte past the buffer end
   always_comb begin
      logic [AW:0] p;
      for (int b = 0; b < NB; b++) begin
         bank_lane[b] = 2'(b) - off[1:0];
         p            = (AW+1)'(off) + (AW+1)'(bank_lane[b]);
         bank_ok[b]   = ({1'b0, bank_lane[b]} < nbytes) && (p < (AW+1)'(BUF_BYTES));
         bank_word[b] = p[AW-1:2];
      end
      for (int i = 0; i < NB; i++) begin
         p         = (AW+1)'(off) + (AW+1)'(i);
         res_ok[i] = (3'(i) < nbytes) && (p < (AW+1)'(BUF_BYTES));
      end
   end

   // Memory port controls
   always_comb begin
      rx_store_ok = fill_ff < LW'(BUF_BYTES);
      fill_next   = rx_store_ok ? fill_ff + LW'(1) : fill_ff;
      tx_re = accept && ((func == pnrx_pkg::FUNC_READ && target == TGT_TX) ||
                         func == pnrx_pkg::FUNC_TX_FETCH);
      rx_re = accept && func == pnrx_pkg::FUNC_READ && target == TGT_RX;
      for (int b = 0; b < NB; b++) begin
         tx_we[b] = accept && func == pnrx_pkg::FUNC_WRITE && target == TGT_TX && bank_ok[b];
         tx_ra[b] = bank_word[b];
         tx_wd[b] = req_bus.wdata[8*bank_lane[b] +: 8];
         rx_we[b] = accept && func == pnrx_pkg::FUNC_RX_BYTE && rx_store_ok &&
                    fill_ff[1:0] == 2'(b);
      end
   end

   // Byte banks of the transmit buffer and the receive ring
   for (genvar b = 0; b < NB; b++) begin : g_bank
      logic [BW-1:0] tx_mem [TXD];
      logic [BW-1:0] rx_mem [RXD];

      always_ff @(posedge clock) begin
         if (tx_we[b]) begin
            tx_mem[tx_ra[b]] <= tx_wd[b];
         end
         if (tx_re) begin
            tx_rd_ff[b] <= tx_mem[tx_ra[b]];
         end
      end

      always_ff @(posedge clock) begin
         if (rx_we[b]) begin
            rx_mem[{head_ff, fill_ff[AW-1:2]}] <= req_bus.rx_data;
         end
         if (rx_re) begin
            rx_rd_ff[b] <= rx_mem[{tail_ff, bank_word[b]}];
         end
      end
   end

   // Packet length store, read at tail and written at head
   always_ff @(posedge clock) begin
      if (accept && func == pnrx_pkg::FUNC_RX_BYTE && req_bus.rx_last) begin
         len_mem[head_ff] <= fill_next;
      end
      if (accept && func == pnrx_pkg::FUNC_READ && target == TGT_RX_LEN) begin
         len_rd_ff <= len_mem[tail_ff];
         len_ok_ff <= len_vld_ff[tail_ff];
      end
   end

   // Update registers and build the stage 1 record
   always_comb begin
      head_in    = head_ff;
      tail_in    = tail_ff;
      tx_len_in  = tx_len_ff;
      fill_in    = fill_ff;
      irq_in     = irq_ff;
      len_vld_in = len_vld_ff;
      meta_in    = '0;
      if (accept) begin
         case (func)
            pnrx_pkg::FUNC_WRITE: begin
               if (target == TGT_TAIL) begin
                  tail_in = req_bus.wdata[QW-1:0];
                  if (req_bus.wdata[QW-1:0] == head_ff) begin
                     irq_in = 1'b0;
                  end
               end else if (target == TGT_SEND_LEN) begin
                  tx_len_in = req_bus.wdata[AW-1:0];
               end
            end
            pnrx_pkg::FUNC_RX_BYTE: begin
               fill_in = fill_next;
               if (req_bus.rx_last) begin
                  len_vld_in[head_ff] = 1'b1;
                  fill_in = '0;
                  head_in = head_ff + QW'(1);
                  irq_in  = 1'b1;
               end
            end
            default: begin
               head_in = head_ff;
            end
         endcase
      end
      meta_in.src     = SRC_VALUE;
      meta_in.fetch   = func == pnrx_pkg::FUNC_TX_FETCH;
      meta_in.off_lo  = off[1:0];
      meta_in.byte_ok = res_ok;
      meta_in.irq     = irq_in;
      if (func == pnrx_pkg::FUNC_READ) begin
         case (target)
            TGT_HEAD:     meta_in.value = 32'(head_ff);
            TGT_TAIL:     meta_in.value = 32'(tail_ff);
            TGT_SEND_LEN: meta_in.value = 32'(tx_len_ff);
            TGT_RX_LEN:   meta_in.src   = SRC_LEN;
            TGT_TX:       meta_in.src   = SRC_TX;
            TGT_RX:       meta_in.src   = SRC_RX;
            default:      meta_in.value = '0;
         endcase
      end else if (func == pnrx_pkg::FUNC_WRITE && target == TGT_SEND) begin
         meta_in.strobe   = 1'b1;
         meta_in.send_len = pnrx_pkg::SEND_W'(tx_len_ff);
      end else if (func == pnrx_pkg::FUNC_TX_FETCH) begin
         meta_in.src = SRC_TX;
      end
   end

   // Assemble little-endian read data from the banks
   always_comb begin
      logic [1:0] b;
      for (int i = 0; i < NB; i++) begin
         b = meta_ff.off_lo + 2'(i);
         if (!meta_ff.byte_ok[i]) begin
            asm_data[8*i +: 8] = '0;
         end else if (meta_ff.src == SRC_TX) begin
            asm_data[8*i +: 8] = tx_rd_ff[b];
         end else begin
            asm_data[8*i +: 8] = rx_rd_ff[b];
         end
      end
   end

   // Form the response
   always_comb begin
      out_in             = out_ff;
      out_in.irq         = meta_ff.irq;
      out_in.send_strobe = meta_ff.strobe;
      out_in.send_length = meta_ff.send_len;
      out_in.tx_byte     = meta_ff.fetch ? asm_data[BW-1:0] : '0;
      case (meta_ff.src)
         SRC_VALUE: out_in.rdata = meta_ff.value;
         SRC_LEN:   out_in.rdata = len_ok_ff ? 32'(len_rd_ff) : '0;
         default:   out_in.rdata = meta_ff.fetch ? '0 : asm_data;
      endcase
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      rsp_valid_in = s1_move ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);
   end

   // Hold control state and advance the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         tx_len_ff    <= '0;
         fill_ff      <= '0;
         irq_ff       <= 1'b0;
         len_vld_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         tx_len_ff    <= tx_len_in;
         fill_ff      <= fill_in;
         irq_ff       <= irq_in;
         len_vld_ff   <= len_vld_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         meta_ff <= meta_in;
      end
      if (s1_move) begin
         out_ff <= out_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.rdata       = out_ff.rdata;
   assign rsp_bus.irq         = out_ff.irq;
   assign rsp_bus.send_strobe = out_ff.send_strobe;
   assign rsp_bus.send_length = out_ff.send_length;
   assign rsp_bus.tx_byte     = out_ff.tx_byte;

endmodule

@@ tb/sv/tb_packet_nic_rx_ring_registers.sv @@
// Self-checking testbench for the packet adapter receive ring and transmit buffer.
`timescale 1ns / 1ps

module tb_packet_nic_rx_ring_registers;
   import pnrx_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS   = 900;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 8;
   localparam int SLOT_W         = $clog2(QUEUE_DEPTH);

   // Any size code other than half or word moves one byte
   localparam logic [SIZE_W-1:0] SIZE_BYTE = SIZE_W'(1);

   typedef struct {
      func_type            func;
      logic [ADDR_W-1:0]   address;
      logic [DATA_W-1:0]   wdata;
      logic [SIZE_W-1:0]   size;
      logic [BYTE_W-1:0]   rx_data;
      logic                rx_last;
      logic [IDX_W-1:0]    tx_index;
   } nic_req_type;

   typedef struct {
      logic [DATA_W-1:0]   rdata;
      logic                irq;
      logic                send_strobe;
      logic [SEND_W-1:0]   send_length;
      logic [BYTE_W-1:0]   tx_byte;
   } nic_rsp_type;

   // Track adapter state, predict each response and compare against the block
   class nic_ring_tracker;
      bit [7:0]          rx_mem [QUEUE_DEPTH*BUF_BYTES];
      bit [11:0]         rx_len [QUEUE_DEPTH];
      int unsigned       rx_known [QUEUE_DEPTH];
      bit [7:0]          tx_mem [BUF_BYTES];
      bit                tx_known [BUF_BYTES];
      bit [SLOT_W-1:0]   head_slot;
      bit [SLOT_W-1:0]   tail_slot;
      bit [SEND_W-1:0]   tx_len;
      int unsigned       rx_fill;
      bit                irq_level;
      nic_rsp_type       rsp_due[$];
      int                errors;

      static function int unsigned access_width(logic [SIZE_W-1:0] size);
         if (size == SIZE_HALF || size == SIZE_WORD)
            return 32'(size);
         return 1;
      endfunction

      // True when every in-buffer byte of the access has been written
      function bit tx_readable(int unsigned off, int unsigned n);
         for (int unsigned i = 0; i < n; i++)
            if (off + i < BUF_BYTES && !tx_known[off + i])
               return 1'b0;
         return 1'b1;
      endfunction

      function bit rx_readable(int unsigned off, int unsigned n);
         for (int unsigned i = 0; i < n; i++)
            if (off + i < BUF_BYTES && off + i >= rx_known[tail_slot])
               return 1'b0;
         return 1'b1;
      endfunction

      // Assemble a little-endian value; bytes past the buffer end read zero
      function logic [31:0] gather(bit rx_side, int unsigned slot, int unsigned off,
                                   int unsigned n);
         logic [31:0] v;
         int unsigned p;
         v = '0;
         for (int unsigned i = 0; i < n; i++) begin
            p = off + i;
            if (p < BUF_BYTES)
               v |= 32'(rx_side ? rx_mem[slot*BUF_BYTES + p] : tx_mem[p]) << (8*i);
         end
         return v;
      endfunction

      function void note_request(nic_req_type r);
         nic_rsp_type e;
         int unsigned a, n, p;
         logic [31:0] val;
         bit          wr;
         e.rdata = '0;
         e.irq = 1'b0;
         e.send_strobe = 1'b0;
         e.send_length = '0;
         e.tx_byte = '0;
         a = 32'(r.address);
         n = access_width(r.size);
         wr = (r.func == FUNC_WRITE);
         val = '0;
         case (r.func)
            FUNC_READ, FUNC_WRITE: begin
               if (a == REG_HEAD) begin
                  val = 32'(head_slot);
               end else if (a == REG_TAIL) begin
                  if (wr) begin
                     tail_slot = SLOT_W'(r.wdata % QUEUE_DEPTH);
                     if (tail_slot == head_slot)
                        irq_level = 1'b0;
                  end
                  val = 32'(tail_slot);
               end else if (a == REG_SEND) begin
                  if (wr) begin
                     e.send_strobe = 1'b1;
                     e.send_length = tx_len;
                  end
               end else if (a == REG_SEND_LEN) begin
                  if (wr)
                     tx_len = SEND_W'(r.wdata % BUF_BYTES);
                  val = 32'(tx_len);
               end else if (a == REG_RX_LEN) begin
                  val = 32'(rx_len[tail_slot]);
               end else if (a >= TX_BASE && a - TX_BASE < BUF_BYTES) begin
                  if (wr) begin
                     for (int unsigned i = 0; i < n; i++) begin
                        p = a - TX_BASE + i;
                        if (p < BUF_BYTES) begin
                           tx_mem[p] = r.wdata[8*i +: 8];
                           tx_known[p] = 1'b1;
                        end
                     end
                  end else begin
                     val = gather(1'b0, 0, a - TX_BASE, n);
                  end
               end else if (a >= RX_BASE && a - RX_BASE < BUF_BYTES) begin
                  val = gather(1'b1, tail_slot, a - RX_BASE, n);
               end
               e.rdata = wr ? '0 : val;
            end
            FUNC_RX_BYTE: begin
               // Fill the slot at head; drop bytes past the buffer end
               if (rx_fill < BUF_BYTES) begin
                  rx_mem[head_slot*BUF_BYTES + rx_fill] = r.rx_data;
                  rx_fill++;
                  if (rx_known[head_slot] < rx_fill)
                     rx_known[head_slot] = rx_fill;
               end
               if (r.rx_last) begin
                  rx_len[head_slot] = 12'(rx_fill);
                  rx_fill = 0;
                  head_slot = head_slot + SLOT_W'(1);
                  irq_level = 1'b1;
               end
            end
            FUNC_TX_FETCH: begin
               if (r.tx_index < BUF_BYTES)
                  e.tx_byte = tx_mem[r.tx_index];
            end
         endcase
         e.irq = irq_level;
         rsp_due.push_back(e);
      endfunction

      function void check_field(string what, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
         end
      endfunction

      function void check_response(nic_rsp_type got);
         nic_rsp_type want;
         if (rsp_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected response: expected none, actual rdata 0x%0h",
                     $time, got.rdata);
            return;
         end
         want = rsp_due.pop_front();
         check_field("rdata", want.rdata, got.rdata);
         check_field("irq", 32'(want.irq), 32'(got.irq));
         check_field("send_strobe", 32'(want.send_strobe), 32'(got.send_strobe));
         check_field("send_length", 32'(want.send_length), 32'(got.send_length));
         check_field("tx_byte", 32'(want.tx_byte), 32'(got.tx_byte));
      endfunction

      function int pending();
         return rsp_due.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   pnrx_req_if req_bus();
   pnrx_rsp_if rsp_bus();

   nic_ring_tracker ring;
   int              burst_left = 0;
   bit              hold_rsp_req = 1'b0;

   packet_nic_rx_ring_registers u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Fill every field but rx_last with noise, then let the caller set what matters
   function automatic nic_req_type blank_request(func_type f);
      nic_req_type r;
      r.func     = f;
      r.address  = ADDR_W'($urandom_range(0, 8191));
      r.wdata    = $urandom;
      r.size     = SIZE_W'($urandom_range(0, 7));
      r.rx_data  = BYTE_W'($urandom_range(0, 255));
      r.rx_last  = 1'b0;
      r.tx_index = IDX_W'($urandom_range(0, BUF_BYTES - 1));
      return r;
   endfunction

   // Favor the low end and the top of the transmit buffer so reads find written bytes
   function automatic int unsigned tx_window();
      case ($urandom_range(0, 3))
         0, 1:    return $urandom_range(0, 63);
         2:       return $urandom_range(BUF_BYTES - 8, BUF_BYTES - 1);
         default: return $urandom_range(0, BUF_BYTES - 1);
      endcase
   endfunction

   function automatic nic_req_type random_request();
      nic_req_type r;
      int unsigned pick, off, known;
      bit          found;
      r = blank_request(FUNC_READ);
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
         // Packet bytes from the link
         r.func = FUNC_RX_BYTE;
         r.rx_last = ($urandom_range(0, 9) == 0);
      end else if (pick < 42) begin
         // Software moves tail: mostly service one slot, sometimes catch up to head
         r.func = FUNC_WRITE;
         r.address = REG_TAIL;
         case ($urandom_range(0, 3))
            0, 1: r.wdata = ($urandom & ~32'(QUEUE_DEPTH - 1))
                            | 32'((ring.tail_slot + 1) % QUEUE_DEPTH);
            2:    r.wdata = ($urandom & ~32'(QUEUE_DEPTH - 1)) | 32'(ring.head_slot);
            default: ;
         endcase
      end else if (pick < 56) begin
         // Read the receive slot at tail, only where bytes have landed
         known = ring.rx_known[ring.tail_slot];
         if (known == 0) begin
            r.address = REG_RX_LEN;
         end else begin
            off = $urandom_range(0, known - 1);
            r.address = ADDR_W'(RX_BASE + off);
            if (!ring.rx_readable(off, nic_ring_tracker::access_width(r.size)))
               r.size = SIZE_BYTE;
         end
      end else if (pick < 68) begin
         r.func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
         case ($urandom_range(0, 6))
            0: r.address = REG_HEAD;
            1: r.address = REG_TAIL;
            2: r.address = REG_SEND;
            3: r.address = REG_SEND_LEN;
            4: r.address = REG_RX_LEN;
            5: r.address = ADDR_W'($urandom_range(REG_RX_LEN + 1, TX_BASE - 1));
            default: r.address = ADDR_W'($urandom_range(RX_BASE + BUF_BYTES, 8191));
         endcase
      end else if (pick < 82) begin
         r.func = FUNC_WRITE;
         r.address = ADDR_W'(TX_BASE + tx_window());
      end else if (pick < 94) begin
         // Read or fetch a written transmit byte; write one if none turns up
         found = 1'b0;
         off = 0;
         for (int t = 0; t < 8 && !found; t++) begin
            off = tx_window();
            found = ring.tx_known[off];
         end
         if (!found) begin
            r.func = FUNC_WRITE;
            r.address = ADDR_W'(TX_BASE + off);
         end else if (pick < 89) begin
            r.address = ADDR_W'(TX_BASE + off);
            if (!ring.tx_readable(off, nic_ring_tracker::access_width(r.size)))
               r.size = SIZE_BYTE;
         end else begin
            r.func = FUNC_TX_FETCH;
            r.tx_index = IDX_W'(off);
         end
      end else begin
         // Noise anywhere on the bus; buffer ranges only take writes here
         r.func = $urandom_range(0, 1) ? FUNC_WRITE : FUNC_READ;
         if (r.func == FUNC_READ && r.address >= TX_BASE && r.address < RX_BASE + BUF_BYTES)
            r.func = FUNC_WRITE;
      end
      return r;
   endfunction

   // Offer one transaction, hold it until accepted, then pace the next burst
   task automatic issue(input nic_req_type it);
      int unsigned gap;
      req_bus.valid    <= 1'b1;
      req_bus.func     <= it.func;
      req_bus.address  <= it.address;
      req_bus.wdata    <= it.wdata;
      req_bus.size     <= it.size;
      req_bus.rx_data  <= it.rx_data;
      req_bus.rx_last  <= it.rx_last;
      req_bus.tx_index <= it.tx_index;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      @(negedge clock);
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
   endtask

   task automatic bus_op(input func_type f, input logic [ADDR_W-1:0] addr,
                         input logic [DATA_W-1:0] data, input logic [SIZE_W-1:0] size);
      nic_req_type it;
      it = blank_request(f);
      it.address = addr;
      it.wdata = data;
      it.size = size;
      issue(it);
   endtask

   // Stop offering and wait for every outstanding response
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do
         @(negedge clock);
      while (ring.pending() != 0);
   endtask

   initial begin : stimulus
      nic_req_type it;
      ring = new();
      req_bus.valid    <= 1'b0;
      req_bus.func     <= '0;
      req_bus.address  <= '0;
      req_bus.wdata    <= '0;
      req_bus.size     <= '0;
      req_bus.rx_data  <= '0;
      req_bus.rx_last  <= 1'b0;
      req_bus.tx_index <= '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Registers after reset, then an unmapped offset
      bus_op(FUNC_READ, REG_HEAD, '0, SIZE_WORD);
      bus_op(FUNC_READ, REG_TAIL, '0, SIZE_WORD);
      bus_op(FUNC_READ, REG_SEND, '0, SIZE_WORD);
      bus_op(FUNC_READ, REG_SEND_LEN, '0, SIZE_WORD);
      bus_op(FUNC_READ, REG_RX_LEN, '0, SIZE_WORD);
      bus_op(FUNC_READ, ADDR_W'(20), '0, SIZE_WORD);

      // Transmit buffer widths, odd size code, unaligned and past-end accesses
      bus_op(FUNC_WRITE, TX_BASE, 32'hFFFF_FFFF, SIZE_WORD);
      bus_op(FUNC_WRITE, ADDR_W'(TX_BASE + 4), 32'h1234_A55A, SIZE_HALF);
      bus_op(FUNC_WRITE, ADDR_W'(TX_BASE + 6), 32'hFFFF_FF80, SIZE_W'(7));
      bus_op(FUNC_WRITE, ADDR_W'(TX_BASE + BUF_BYTES - 3), 32'h8765_4321, SIZE_WORD);
      bus_op(FUNC_READ, ADDR_W'(TX_BASE + BUF_BYTES - 3), '0, SIZE_WORD);
      bus_op(FUNC_READ, ADDR_W'(TX_BASE + 3), '0, SIZE_WORD);
      it = blank_request(FUNC_TX_FETCH);
      it.tx_index = '0;
      issue(it);
      it.tx_index = '1;
      issue(it);

      // Send length wraps modulo the buffer size; strobe carries it
      bus_op(FUNC_WRITE, REG_SEND_LEN, 32'hFFFF_FFFF, SIZE_WORD);
      bus_op(FUNC_WRITE, REG_SEND, 32'hFFFF_FFFF, SIZE_WORD);
      bus_op(FUNC_WRITE, REG_SEND_LEN, 32'(BUF_BYTES), SIZE_WORD);
      bus_op(FUNC_WRITE, REG_SEND, '0, SIZE_WORD);

      // Writes to read-only targets and unmapped space are dropped
      bus_op(FUNC_WRITE, REG_HEAD, 32'hFFFF_FFFF, SIZE_WORD);
      bus_op(FUNC_WRITE, REG_RX_LEN, 32'hFFFF_FFFF, SIZE_WORD);
      bus_op(FUNC_WRITE, RX_BASE, 32'hFFFF_FFFF, SIZE_WORD);
      bus_op(FUNC_WRITE, '1, 32'hFFFF_FFFF, SIZE_WORD);
      bus_op(FUNC_READ, '1, '0, SIZE_WORD);

      // Short packet raises the interrupt; only tail equal to head clears it
      it = blank_request(FUNC_RX_BYTE);
      it.rx_data = 8'h00;
      issue(it);
      it.rx_data = 8'hFF;
      it.rx_last = 1'b1;
      issue(it);
      bus_op(FUNC_READ, RX_BASE, '0, SIZE_HALF);
      bus_op(FUNC_READ, REG_RX_LEN, '0, SIZE_WORD);
      bus_op(FUNC_WRITE, REG_TAIL, 32'hFFFF_FFE0, SIZE_WORD);
      bus_op(FUNC_WRITE, REG_TAIL, 32'h0000_0021, SIZE_WORD);
      bus_op(FUNC_READ, REG_RX_LEN, '0, SIZE_WORD);

      // Random traffic with one long response stall and one full drain
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k == RANDOM_ITEMS / 3)
            hold_rsp_req = 1'b1;
         if (k == 2 * RANDOM_ITEMS / 3)
            drain_responses();
         issue(random_request());
      end

      drain_responses();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (ring.errors == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // Response backpressure: modes are re-picked at random, plus one long hold
   initial begin : rsp_stall
      int unsigned cyc, mode;
      cyc = 0;
      mode = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp_req) begin
            hold_rsp_req = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (cyc % 50 == 0)
               mode = $urandom_range(0, 3);
            case (mode)
               0:       rsp_bus.ready <= 1'b1;
               1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
               2:       rsp_bus.ready <= (cyc % 4 == 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            endcase
            cyc++;
         end
      end
   end

   // Note accepted requests and check accepted responses
   always @(posedge clock) begin : observe
      nic_req_type seen_req;
      nic_rsp_type seen_rsp;
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen_req.func     = func_type'(req_bus.func);
         seen_req.address  = req_bus.address;
         seen_req.wdata    = req_bus.wdata;
         seen_req.size     = req_bus.size;
         seen_req.rx_data  = req_bus.rx_data;
         seen_req.rx_last  = req_bus.rx_last;
         seen_req.tx_index = req_bus.tx_index;
         ring.note_request(seen_req);
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_rsp.rdata       = rsp_bus.rdata;
         seen_rsp.irq         = rsp_bus.irq;
         seen_rsp.send_strobe = rsp_bus.send_strobe;
         seen_rsp.send_length = rsp_bus.send_length;
         seen_rsp.tx_byte     = rsp_bus.tx_byte;
         ring.check_response(seen_rsp);
      end
   end

   // End the run when no transaction moves on either side for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ packet_nic_rx_ring_registers.f @@
rtl/core/pnrx_pkg.sv
rtl/core/pnrx_chan_if.sv
rtl/core/packet_nic_rx_ring_registers.sv
tb/sv/tb_packet_nic_rx_ring_registers.sv
